/* rtl/core/ball_rk4_bounce_step_assert.svh */
// Assertion macros used by the ball step sequencer.
// Pure text macros; no dependencies.
`ifndef BALL_RK4_BOUNCE_STEP_ASSERT_SVH
`define BALL_RK4_BOUNCE_STEP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BRBS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("brbs assertion failed");

// Next-cycle implication, disabled during reset
`define BRBS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("brbs assertion failed");

`endif

/* rtl/core/brbs_pkg.sv */
// Types, constants and rounding helpers for the ball step block.
// No dependencies.
`default_nettype none

package brbs_pkg;

  // fixed-point formats
  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 20;
  localparam int VEL_W     = 24;
  localparam int DT_W      = 11;
  localparam int WP_W      = 24;   // working position, signed
  localparam int WV_W      = 26;   // working velocity / acceleration, signed
  localparam int ACC_W     = 28;   // RK4 weighted sums
  localparam int T_W       = 20;   // scaled quotient before the divide by six
  localparam int FD_W      = 20;   // friction step

  // shared multiplier operand widths
  localparam int MA_W = 28;
  localparam int MB_W = 19;
  localparam int PR_W = MA_W + MB_W;

  // physics constants
  localparam int GRAV_FX  = 980 * (2 ** FRAC_BITS);
  localparam int FRIC_FX  = 500 * (2 ** FRAC_BITS);
  localparam int DRAG_Q16 = 6554;
  localparam int DAMP_Q16 = 45875;

  // divide by 6*2^20: add 3*2^20 (half the divisor), shift right by 20, then multiply by floor(2^20/6)
  localparam int DIV_SH   = 20;
  localparam int DIV_HALF = 3 * (2 ** DIV_SH);
  localparam int RECIP6   = (2 ** DIV_SH) / 6;

  localparam int POS_MAX = (2 ** POS_W) - 1;
  localparam int VEL_MAX = (2 ** (VEL_W - 1)) - 1;
  localparam int VEL_MIN = -(2 ** (VEL_W - 1));

  // command codes
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // micro-operations, each one multiply plus writeback
  typedef enum logic [4:0] {
    U_K1, U_V2, U_K2, U_V3, U_K3, U_V4, U_K4,
    U_PT, U_PQ, U_VT, U_VQ,
    U_FD, U_FLR, U_CEIL, U_LEFT, U_RIGHT
  } uop_t;

  typedef enum logic [1:0] {RND_Q16, RND_Q20, RND_Q21} rnd_t;

  // sequencer to datapath control
  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic start;
    logic load;
    logic issue;
    logic wb;
    logic axis;
    uop_t uop;
  } ctrl_t;

  // signed shift right, rounded half away from zero
  function automatic logic signed [PR_W-1:0] rnd_shr(input logic signed [PR_W-1:0] p,
                                                     input rnd_t kind);
    logic [PR_W-1:0] mag;
    logic [PR_W-1:0] q;
    mag = p[PR_W-1] ? PR_W'(-p) : PR_W'(p);
    case (kind)
      RND_Q16: q = (mag + (PR_W'(1) << 15)) >> 16;
      RND_Q20: q = (mag + (PR_W'(1) << 19)) >> 20;
      RND_Q21: q = (mag + (PR_W'(1) << 20)) >> 21;
      default: q = '0;
    endcase
    rnd_shr = p[PR_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [WV_W-1:0] v);
    if (v > WV_W'(VEL_MAX)) begin
      sat_vel = VEL_W'(VEL_MAX);
    end else if (v < WV_W'(VEL_MIN)) begin
      sat_vel = VEL_W'(VEL_MIN);
    end else begin
      sat_vel = VEL_W'(v);
    end
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [WP_W-1:0] p);
    if (p < 0) begin
      sat_pos = '0;
    end else if (p > WP_W'(POS_MAX)) begin
      sat_pos = POS_W'(POS_MAX);
    end else begin
      sat_pos = POS_W'(p);
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/brbs_mul.sv */
// Shared signed multiplier with registered product.
// Depends on brbs_pkg.
`default_nettype none

module brbs_mul (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire  logic signed [brbs_pkg::MA_W-1:0] op_a,
  input  wire  logic signed [brbs_pkg::MB_W-1:0] op_b,
  output logic signed [brbs_pkg::PR_W-1:0]     prod_r
);
  import brbs_pkg::*;

  logic signed [PR_W-1:0] prod_nxt;

  // one product per issue cycle
  assign prod_nxt = PR_W'(op_a) * PR_W'(op_b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/brbs_seq.sv */
// Sequencer: request handshake and micro-operation order for one step.
// Depends on brbs_pkg and ball_rk4_bounce_step_assert.svh.
`default_nettype none
`include "ball_rk4_bounce_step_assert.svh"

module brbs_seq (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_cmd,
  input  wire               out_ready,
  output brbs_pkg::ctrl_t   ctl
);
  import brbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WB    = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  uop_t   uop_r, uop_nxt;
  logic   axis_r, axis_nxt;

  // next state and micro-op
  always_comb begin
    state_nxt = state_r;
    uop_nxt   = uop_r;
    axis_nxt  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_ISSUE;
            uop_nxt   = U_K1;
            axis_nxt  = 1'b0;
          end
        end
      end
      S_ISSUE: state_nxt = S_WB;
      S_WB: begin
        if (uop_r == U_RIGHT) begin
          state_nxt = S_OUT;
        end else if (uop_r == U_VQ && !axis_r) begin
          state_nxt = S_ISSUE;
          uop_nxt   = U_K1;
          axis_nxt  = 1'b1;
        end else begin
          state_nxt = S_ISSUE;
          uop_nxt   = uop_t'(uop_r + 5'd1);
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      uop_r   <= U_K1;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      uop_r   <= uop_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // control outputs
  always_comb begin
    ctl.in_ready  = (state_r == S_IDLE);
    ctl.out_valid = (state_r == S_OUT);
    ctl.start     = (state_r == S_IDLE) && in_valid && (in_cmd == CMD_STEP);
    ctl.load      = (state_r == S_IDLE) && in_valid && (in_cmd == CMD_LOAD);
    ctl.issue     = (state_r == S_ISSUE);
    ctl.wb        = (state_r == S_WB);
    ctl.axis      = axis_r;
    ctl.uop       = uop_r;
  end

  `BRBS_ASSERT_IMP(a_idle_excl, clk, rst_n, ctl.in_ready, !ctl.out_valid && !ctl.wb)
  `BRBS_ASSERT_NXT(a_load_out, clk, rst_n, ctl.load, ctl.out_valid)
  `BRBS_ASSERT_NXT(a_start_k1, clk, rst_n, ctl.start, ctl.issue && ctl.uop == U_K1 && !ctl.axis)
  `BRBS_ASSERT_NXT(a_issue_wb, clk, rst_n, ctl.issue, ctl.wb)

endmodule

`default_nettype wire

/* rtl/core/ball_rk4_bounce_step.sv */
// Top level: one ball advanced by RK4 with drag, gravity and wall bounces.
// Depends on brbs_pkg, brbs_mul, brbs_seq.
//
//   Channel | Dir | Ports                                  | Handshake
//   --------+-----+----------------------------------------+-----------------
//   in      | in  | in_tvalid/in_tready, in_tdata, in_tuser | valid & ready
//   out     | out | out_tvalid/out_tready, out_tdata       | valid & ready
//   cfg     | in  | cfg_valid/cfg_ready, cfg_index, cfg_data| valid & ready
//
// A step request runs 27 micro-operations from accept to result on the
// one shared 28x19 multiplier, each an issue state followed by a writeback state.
// A load request shows its result the cycle after accept.
// in_tready is high only while idle; the result holds until out_tready.
// rst_n is synchronous; reset loads the documented register and state values.
// cfg_ready is always high.
`default_nettype none

module ball_rk4_bounce_step (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [15:0]  in_tdata,    // [10:0] step_time, rest zero
  input  wire  [0:0]   in_tuser,    // [0] cmd
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [95:0]  out_tdata,   // pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                                    // hit_floor, hit_ceiling, hit_left, hit_right, pad
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [2:0]   cfg_index,
  input  wire  [23:0]  cfg_data
);
  import brbs_pkg::*;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_IX     = 3'd3;
  localparam logic [2:0] CFG_IY     = 3'd4;
  localparam logic [2:0] CFG_IVX    = 3'd5;
  localparam logic [2:0] CFG_IVY    = 3'd6;

  ctrl_t ctl;

  // configuration registers
  logic [11:0]              aw_r, ah_r;
  logic [10:0]              rad_r;
  logic [POS_W-1:0]         ix_r, iy_r;
  logic signed [VEL_W-1:0]  ivx_r, ivy_r;

  // architectural state and result flags
  logic [POS_W-1:0]         pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [VEL_W-1:0]  vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic                     hf_r, hf_nxt, hc_r, hc_nxt, hl_r, hl_nxt, hr_r, hr_nxt;

  // working registers
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic signed [WP_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic signed [WV_W-1:0]   v1_r, v1_nxt, vcur_r, vcur_nxt, k_r, k_nxt;
  logic signed [ACC_W-1:0]  kacc_r, kacc_nxt, vacc_r, vacc_nxt;
  logic [T_W-1:0]           t_r, t_nxt;
  logic                     neg_r, neg_nxt;
  logic [FD_W-1:0]          fd_r, fd_nxt;

  // multiplier
  logic signed [MA_W-1:0]   op_a;
  logic signed [MB_W-1:0]   op_b;
  logic signed [MB_W-1:0]   dt_b;
  logic signed [PR_W-1:0]   prod_r;

  // writeback helpers
  logic signed [PR_W-1:0]   rq16, rq20, rq21;
  logic [PR_W-1:0]          pmag;
  logic signed [WV_W-1:0]   knew, vm20, vm21, vsum;
  logic [T_W-1:0]           q0, qc;
  logic [T_W+1:0]           six_q, rem;
  logic signed [T_W:0]      dq;
  logic signed [WP_W-1:0]   r_fx, w_fx, h_fx, px_fin;
  logic                     floor_hit, ceil_hit, left_hit, right_hit;
  logic signed [VEL_W-1:0]  bnc, fric;
  logic [VEL_W:0]           vx_mag;

  assign cfg_ready  = 1'b1;
  assign in_tready  = ctl.in_ready;
  assign out_tvalid = ctl.out_valid;
  assign out_tdata  = {4'b0, hr_r, hl_r, hc_r, hf_r, vel_y_r, vel_x_r, pos_y_r, pos_x_r};

  brbs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser[0]),
    .out_ready (out_tready),
    .ctl       (ctl)
  );

  brbs_mul u_mul (
    .clk    (clk),
    .en     (ctl.issue),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // operand select per micro-op
  assign dt_b = $signed(MB_W'(dt_r));

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctl.uop)
      U_K1, U_K2, U_K3, U_K4: begin
        op_a = MA_W'(vcur_r);
        op_b = MB_W'(DRAG_Q16);
      end
      U_V2, U_V3, U_V4: begin
        op_a = MA_W'(k_r);
        op_b = dt_b;
      end
      U_PT: begin
        op_a = vacc_r;
        op_b = dt_b;
      end
      U_VT: begin
        op_a = kacc_r;
        op_b = dt_b;
      end
      U_PQ, U_VQ: begin
        op_a = $signed(MA_W'(t_r));
        op_b = MB_W'(RECIP6);
      end
      U_FD: begin
        op_a = MA_W'(FRIC_FX);
        op_b = dt_b;
      end
      U_FLR, U_CEIL: begin
        op_a = MA_W'(vel_y_r);
        op_b = MB_W'(DAMP_Q16);
      end
      U_LEFT, U_RIGHT: begin
        op_a = MA_W'(vel_x_r);
        op_b = MB_W'(DAMP_Q16);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // rounding of the product
  assign rq16 = rnd_shr(prod_r, RND_Q16);
  assign rq20 = rnd_shr(prod_r, RND_Q20);
  assign rq21 = rnd_shr(prod_r, RND_Q21);
  assign pmag = prod_r[PR_W-1] ? PR_W'(-prod_r) : PR_W'(prod_r);

  // acceleration and RK4 midpoint and endpoint velocities
  assign knew = (ctl.axis ? WV_W'(GRAV_FX) : WV_W'(0)) - WV_W'(rq16);
  assign vm21 = v1_r + WV_W'(rq21);
  assign vm20 = v1_r + WV_W'(rq20);

  // quotient by six with one correction step
  assign q0    = prod_r[DIV_SH +: T_W];
  assign six_q = {q0, 2'b00} + {1'b0, q0, 1'b0};
  assign rem   = {2'b00, t_r} - six_q;
  assign qc    = (rem >= (T_W+2)'(6)) ? q0 + T_W'(1) : q0;
  assign dq    = neg_r ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  assign vsum  = v1_r + WV_W'(dq);

  // wall geometry in fixed point
  assign r_fx = $signed(WP_W'(rad_r) << FRAC_BITS);
  assign w_fx = $signed(WP_W'(aw_r) << FRAC_BITS);
  assign h_fx = $signed(WP_W'(ah_r) << FRAC_BITS);

  assign floor_hit = (py_r + r_fx) > h_fx;
  assign ceil_hit  = (py_r - r_fx) < 0;
  assign left_hit  = (px_r - r_fx) < 0;
  assign right_hit = (px_r + r_fx) > w_fx;
  assign px_fin    = right_hit ? (w_fx - r_fx) : px_r;

  // bounce and ground friction
  assign bnc    = VEL_W'(-rq16);
  assign vx_mag = vel_x_r[VEL_W-1] ? (VEL_W+1)'(-vel_x_r) : (VEL_W+1)'(vel_x_r);
  always_comb begin
    if (vx_mag < (VEL_W+1)'(fd_r)) begin
      fric = '0;
    end else if (vel_x_r > 0) begin
      fric = vel_x_r - $signed(VEL_W'(fd_r));
    end else begin
      fric = vel_x_r + $signed(VEL_W'(fd_r));
    end
  end

  // datapath next values
  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    vel_x_nxt = vel_x_r;
    vel_y_nxt = vel_y_r;
    hf_nxt    = hf_r;
    hc_nxt    = hc_r;
    hl_nxt    = hl_r;
    hr_nxt    = hr_r;
    dt_nxt    = dt_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    v1_nxt    = v1_r;
    vcur_nxt  = vcur_r;
    k_nxt     = k_r;
    kacc_nxt  = kacc_r;
    vacc_nxt  = vacc_r;
    t_nxt     = t_r;
    neg_nxt   = neg_r;
    fd_nxt    = fd_r;

    if (ctl.load) begin
      pos_x_nxt = ix_r;
      pos_y_nxt = iy_r;
      vel_x_nxt = ivx_r;
      vel_y_nxt = ivy_r;
      hf_nxt    = 1'b0;
      hc_nxt    = 1'b0;
      hl_nxt    = 1'b0;
      hr_nxt    = 1'b0;
    end else if (ctl.start) begin
      dt_nxt   = in_tdata[DT_W-1:0];
      px_nxt   = WP_W'(pos_x_r);
      py_nxt   = WP_W'(pos_y_r);
      v1_nxt   = WV_W'(vel_x_r);
      vcur_nxt = WV_W'(vel_x_r);
      hf_nxt   = 1'b0;
      hc_nxt   = 1'b0;
      hl_nxt   = 1'b0;
      hr_nxt   = 1'b0;
    end else if (ctl.wb) begin
      case (ctl.uop)
        U_K1: begin
          k_nxt    = knew;
          kacc_nxt = ACC_W'(knew);
          vacc_nxt = ACC_W'(v1_r);
        end
        U_K2, U_K3: begin
          k_nxt    = knew;
          kacc_nxt = kacc_r + (ACC_W'(knew) <<< 1);
        end
        U_K4: kacc_nxt = kacc_r + ACC_W'(knew);
        U_V2, U_V3: begin
          vcur_nxt = vm21;
          vacc_nxt = vacc_r + (ACC_W'(vm21) <<< 1);
        end
        U_V4: begin
          vcur_nxt = vm20;
          vacc_nxt = vacc_r + ACC_W'(vm20);
        end
        U_PT, U_VT: begin
          neg_nxt = prod_r[PR_W-1];
          t_nxt   = T_W'((pmag + PR_W'(DIV_HALF)) >> DIV_SH);
        end
        U_PQ: begin
          if (ctl.axis) begin
            py_nxt = py_r + WP_W'(dq);
          end else begin
            px_nxt = px_r + WP_W'(dq);
          end
        end
        U_VQ: begin
          if (ctl.axis) begin
            vel_y_nxt = sat_vel(vsum);
          end else begin
            vel_x_nxt = sat_vel(vsum);
            v1_nxt    = WV_W'(vel_y_r);
            vcur_nxt  = WV_W'(vel_y_r);
          end
        end
        U_FD: fd_nxt = FD_W'(rq20);
        U_FLR: begin
          if (floor_hit) begin
            hf_nxt    = 1'b1;
            py_nxt    = h_fx - r_fx;
            vel_y_nxt = bnc;
            vel_x_nxt = fric;
          end
        end
        U_CEIL: begin
          if (ceil_hit) begin
            hc_nxt    = 1'b1;
            py_nxt    = r_fx;
            vel_y_nxt = bnc;
          end
        end
        U_LEFT: begin
          if (left_hit) begin
            hl_nxt    = 1'b1;
            px_nxt    = r_fx;
            vel_x_nxt = bnc;
          end
        end
        U_RIGHT: begin
          if (right_hit) begin
            hr_nxt    = 1'b1;
            vel_x_nxt = bnc;
          end
          px_nxt    = px_fin;
          pos_x_nxt = sat_pos(px_fin);
          pos_y_nxt = sat_pos(py_r);
        end
        default: k_nxt = k_r;
      endcase
    end
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r    <= 12'd800;
      ah_r    <= 12'd600;
      rad_r   <= 11'd10;
      ix_r    <= POS_W'(102400);
      iy_r    <= POS_W'(76800);
      ivx_r   <= '0;
      ivy_r   <= '0;
      pos_x_r <= POS_W'(102400);
      pos_y_r <= POS_W'(76800);
      vel_x_r <= '0;
      vel_y_r <= '0;
      hf_r    <= 1'b0;
      hc_r    <= 1'b0;
      hl_r    <= 1'b0;
      hr_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  aw_r  <= cfg_data[11:0];
          CFG_HEIGHT: ah_r  <= cfg_data[11:0];
          CFG_RADIUS: rad_r <= cfg_data[10:0];
          CFG_IX:     ix_r  <= cfg_data[POS_W-1:0];
          CFG_IY:     iy_r  <= cfg_data[POS_W-1:0];
          CFG_IVX:    ivx_r <= $signed(cfg_data[VEL_W-1:0]);
          CFG_IVY:    ivy_r <= $signed(cfg_data[VEL_W-1:0]);
          default:    aw_r  <= aw_r;
        endcase
      end
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      vel_x_r <= vel_x_nxt;
      vel_y_r <= vel_y_nxt;
      hf_r    <= hf_nxt;
      hc_r    <= hc_nxt;
      hl_r    <= hl_nxt;
      hr_r    <= hr_nxt;
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    dt_r   <= dt_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    v1_r   <= v1_nxt;
    vcur_r <= vcur_nxt;
    k_r    <= k_nxt;
    kacc_r <= kacc_nxt;
    vacc_r <= vacc_nxt;
    t_r    <= t_nxt;
    neg_r  <= neg_nxt;
    fd_r   <= fd_nxt;
  end

endmodule

`default_nettype wire
